// ===== src/swq_pkg.sv =====
// ----------------------------------------------------------------------------
// swq_pkg
// shared types and constants for the semaphore with wait queue
// ----------------------------------------------------------------------------
package swq_pkg;

    localparam int TID_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = 1;

    // register indexes, byte address is 4 * index
    localparam logic [REG_IDX_W-1:0] REG_INITIAL_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_LOCK_MODE     = 1'b1;

    localparam logic [COUNT_W-1:0] INITIAL_COUNT_RESET = 16'd1;

    // request actions
    localparam logic ACT_WAIT   = 1'b0;
    localparam logic ACT_SIGNAL = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BLOCKED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_SIG_NONE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_SIG_WOKE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } swq_state_t;

    // configuration values and reload strobe
    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] initial_count;
        logic               lock_mode;
    } swq_cfg_t;

    // commands into the wait queue
    typedef struct packed {
        logic             rd_en;
        logic             push;
        logic             pop;
        logic             clear;
        logic [TID_W-1:0] wdata;
    } swq_qcmd_t;

    // wait queue status
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [TID_W-1:0] rdata;
    } swq_qstat_t;

endpackage

// ===== src/swq_cfg.sv =====
// ----------------------------------------------------------------------------
// swq_cfg
// apb register file: initial count and lock mode
// ----------------------------------------------------------------------------
module swq_cfg
    import swq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output swq_cfg_t           cfg
);

    logic [COUNT_W-1:0]   initial_count_reg;
    logic                 lock_mode_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_count_reg <= INITIAL_COUNT_RESET;
            lock_mode_reg     <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_INITIAL_COUNT: initial_count_reg <= pwdata[COUNT_W-1:0];
                REG_LOCK_MODE:     lock_mode_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_INITIAL_COUNT: prdata = {{(PDATA_W-COUNT_W){1'b0}}, initial_count_reg};
            REG_LOCK_MODE:     prdata = {{(PDATA_W-1){1'b0}}, lock_mode_reg};
            default:           prdata = '0;
        endcase
    end

    // the reload strobe carries the freshly written count
    assign cfg.load          = wr_en && (reg_idx == REG_INITIAL_COUNT);
    assign cfg.initial_count = pwdata[COUNT_W-1:0];
    assign cfg.lock_mode     = lock_mode_reg;

endmodule

// ===== src/swq_queue.sv =====
// ----------------------------------------------------------------------------
// swq_queue
// circular wait queue of thread ids in a synchronous memory
// ----------------------------------------------------------------------------
module swq_queue
    import swq_pkg::*;
#(
    parameter int WAIT_DEPTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  swq_qcmd_t  cmd,
    output swq_qstat_t stat
);

    localparam int PTR_W  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int USED_W = $clog2(WAIT_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(WAIT_DEPTH - 1);
    localparam logic [USED_W-1:0] FULL_USED = USED_W'(WAIT_DEPTH);

    logic [TID_W-1:0]  mem [WAIT_DEPTH];
    logic [TID_W-1:0]  rdata_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [USED_W-1:0] used_reg, used_next;

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= cmd.wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[head_reg];
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        used_next = used_reg;
        if (cmd.clear) begin
            head_next = '0;
            tail_next = '0;
            used_next = '0;
        end else if (cmd.push) begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
            used_next = used_reg + 1'b1;
        end else if (cmd.pop) begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
            used_next = used_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            used_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            used_reg <= used_next;
        end
    end

    assign stat.empty = (used_reg == '0);
    assign stat.full  = (used_reg == FULL_USED);
    assign stat.rdata = rdata_reg;

endmodule

// ===== src/semaphore_with_wait_queue_core.sv =====
// ----------------------------------------------------------------------------
// semaphore_with_wait_queue_core
// counting semaphore with a fifo of blocked thread ids and optional lock mode
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one request (action 0 wait, 1 signal, plus thread id) under
//   valid/ready. m_* returns exactly one result per request: status, the
//   woken thread id and the count after the request.
//   a request is handled in two steps: the accept edge issues the read of the
//   queue head from the wait memory, the following edge resolves the request,
//   writes the queue memory on a push and loads the output register.
//   the next request is taken only after the previous one is resolved, since
//   the registered queue memory read is followed by the read-modify-write of
//   count, holder and pointers.
//   the output register lets a request be accepted while the previous result
//   is being taken; if m_ready stays low the result holds and s_ready drops.
//   reset (aresetn low, synchronous) sets count to 1, lock mode off, no
//   holder and an empty queue; queue memory contents are never cleared since
//   only written entries are ever used.
//   writing initial_count over apb reloads the count (capped at COUNT_MAX),
//   empties the queue and clears the holder; configure only while idle.
// ----------------------------------------------------------------------------
module semaphore_with_wait_queue_core
    import swq_pkg::*;
#(
    parameter int WAIT_DEPTH = 16,
    parameter int COUNT_MAX  = 65535
) (
    input  logic                aclk,
    input  logic                aresetn,
    // apb configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [TID_W-1:0]    s_thread_id,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [TID_W-1:0]    m_woken_thread,
    output logic [COUNT_W-1:0]  m_count_now
);

    localparam logic [COUNT_W-1:0] CMAX = COUNT_W'(COUNT_MAX);

    swq_cfg_t   cfg;
    swq_qcmd_t  qcmd;
    swq_qstat_t qstat;

    // request state machine
    swq_state_t state_reg, state_next;
    logic       req_accept;

    // captured request
    logic             action_reg;
    logic [TID_W-1:0] tid_reg;

    // semaphore state
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TID_W-1:0]   holder_id_reg, holder_id_next;
    logic               holder_valid_reg, holder_valid_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [TID_W-1:0]    m_woken_reg, m_woken_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic is_holder;

    swq_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swq_queue #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (qcmd),
        .stat    (qstat)
    );

    // take a request when idle and the result slot is free or draining
    assign s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign req_accept = s_valid && s_ready;
    assign is_holder  = holder_valid_reg && (holder_id_reg == tid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            count_reg        <= (INITIAL_COUNT_RESET > CMAX) ? CMAX : INITIAL_COUNT_RESET;
            holder_id_reg    <= '0;
            holder_valid_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            holder_id_reg    <= holder_id_next;
            holder_valid_reg <= holder_valid_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (req_accept) begin
            action_reg <= s_action;
            tid_reg    <= s_thread_id;
        end
        m_status_reg <= m_status_next;
        m_woken_reg  <= m_woken_next;
        m_count_reg  <= m_count_next;
    end

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        holder_id_next    = holder_id_reg;
        holder_valid_next = holder_valid_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_woken_next      = m_woken_reg;
        m_count_next      = m_count_reg;

        // head read is issued on accept, data is ready in the exec cycle
        qcmd.rd_en = req_accept;
        qcmd.push  = 1'b0;
        qcmd.pop   = 1'b0;
        qcmd.clear = 1'b0;
        qcmd.wdata = tid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (req_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b1;
                m_woken_next = '0;
                if (action_reg == ACT_WAIT) begin
                    if (cfg.lock_mode && is_holder) begin
                        // holder re-acquires, nothing changes
                        m_status_next = STATUS_GRANTED;
                    end else if (count_reg != '0) begin
                        count_next    = count_reg - 1'b1;
                        m_status_next = STATUS_GRANTED;
                        if (cfg.lock_mode) begin
                            holder_id_next    = tid_reg;
                            holder_valid_next = 1'b1;
                        end
                    end else if (qstat.full) begin
                        m_status_next = STATUS_FULL;
                    end else begin
                        qcmd.push     = 1'b1;
                        m_status_next = STATUS_BLOCKED;
                    end
                end else begin
                    if (cfg.lock_mode && !is_holder) begin
                        // release by a non-holder is dropped
                        m_status_next = STATUS_IGNORED;
                    end else begin
                        if (cfg.lock_mode) begin
                            holder_id_next    = '0;
                            holder_valid_next = 1'b0;
                        end
                        if (!qstat.empty) begin
                            qcmd.pop      = 1'b1;
                            m_woken_next  = qstat.rdata;
                            m_status_next = STATUS_SIG_WOKE;
                        end else begin
                            m_status_next = STATUS_SIG_NONE;
                        end
                        // saturating increment
                        count_next = (count_reg >= CMAX) ? CMAX : count_reg + 1'b1;
                    end
                end
                m_count_next = count_next;
            end
            default: state_next = ST_IDLE;
        endcase

        // initial_count write reloads count, queue and holder
        if (cfg.load) begin
            qcmd.clear        = 1'b1;
            count_next        = (cfg.initial_count > CMAX) ? CMAX : cfg.initial_count;
            holder_id_next    = '0;
            holder_valid_next = 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_woken_thread = m_woken_reg;
    assign m_count_now    = m_count_reg;

endmodule
